/* hdl/zipc_pkg.sv */
// Shared types and constants for the traditional ZIP stream decrypt core.
// Holds the request/response structs, operation codes, the ALU command
// codes and the constant CRC-32 byte table. No dependencies.
package zipc_pkg;

    localparam int HDR_CNT_W = 4;

    localparam logic [1:0] OP_RESTART = 2'd0;
    localparam logic [1:0] OP_ABSORB  = 2'd1;
    localparam logic [1:0] OP_DECRYPT = 2'd2;

    localparam logic [31:0] KEY_A_INIT = 32'h1234_5678;
    localparam logic [31:0] KEY_B_INIT = 32'h2345_6789;
    localparam logic [31:0] KEY_C_INIT = 32'h3456_7890;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] LCG_MUL    = 32'd134775813;

    // shared unit commands
    localparam logic ALU_MUL = 1'b0;
    localparam logic ALU_CRC = 1'b1;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       header_done;
        logic       header_match;
    } rsp_t;

    typedef struct packed {
        logic        sel;
        logic [31:0] opa;
        logic [31:0] opb;
    } alu_cmd_t;

    typedef logic [255:0][31:0] crc_table_t;

    function automatic crc_table_t crc_build();
        crc_table_t tab;
        logic [31:0] v;
        for (int i = 0; i < 256; i++)
        begin
            v = 32'(i);
            for (int b = 0; b < 8; b++)
            begin
                v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
            end
            tab[i] = v;
        end
        return tab;
    endfunction

    localparam crc_table_t CRC_TABLE = crc_build();

endpackage

/* hdl/zipc_alu.sv */
// Shared arithmetic unit: 32x32 multiply (low word) or one raw CRC-32 byte step.
// Depends on zipc_pkg for the command struct and the CRC table.
module zipc_alu (
    input  zipc_pkg::alu_cmd_t cmd,
    output logic [31:0]        res
);
    import zipc_pkg::*;

    logic [31:0] prod;
    logic [7:0]  idx;

    // only the low word of the product is ever used
    assign prod = cmd.opa * cmd.opb;
    // CRC: opa = running crc, opb[7:0] = byte
    assign idx  = cmd.opa[7:0] ^ cmd.opb[7:0];

    always_comb
    begin
        case (cmd.sel)
            ALU_MUL: res = prod;
            default: res = (cmd.opa >> 8) ^ CRC_TABLE[idx];
        endcase
    end

endmodule

/* hdl/zip_traditional_stream_decrypt.sv */
// Top level of the traditional ZIP stream decrypt core: key registers,
// sequencer, response register and APB register port.
// Depends on zipc_pkg and zipc_alu.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  req     | in        | req_valid/req_stall | operation, data_byte
//  rsp     | out       | rsp_valid/rsp_stall | plain_byte, header_done, match
//  apb     | in/out    | psel/penable/pready | header check value at address 0
//
// A decrypt request holds req_stall high through the keystream multiply,
// key_a CRC step, key_b multiply, key_c CRC step and response load, the four
// arithmetic steps all through the one shared multiply/CRC unit; the next
// request is taken only once the core is back in idle. Password bytes skip
// the keystream multiply; restart and unused codes go straight to the response
// load. rsp_stall only holds the final load; the next request is taken while
// a response still waits. Reset restores the initial keys at once.
module zip_traditional_stream_decrypt #(
    parameter int HEADER_BYTES = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  zipc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output zipc_pkg::rsp_t rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import zipc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_KS   = 3'd1;  // keystream multiply
    localparam logic [2:0] S_KA   = 3'd2;  // key_a crc step
    localparam logic [2:0] S_KB   = 3'd3;  // key_b lcg step
    localparam logic [2:0] S_KC   = 3'd4;  // key_c crc step
    localparam logic [2:0] S_OUT  = 3'd5;  // load response

    localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES);
    localparam logic [HDR_CNT_W-1:0] HDR_ONE  = HDR_CNT_W'(1);

    logic [2:0]           state_reg, state_next;
    logic [31:0]          key_a_reg, key_a_next;
    logic [31:0]          key_b_reg, key_b_next;
    logic [31:0]          key_c_reg, key_c_next;
    logic [HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]           check_reg;
    logic [1:0]           op_reg, op_next;
    logic [7:0]           byte_reg, byte_next;   // absorb byte; plain on decrypt
    logic                 done_reg, done_next;
    logic                 match_reg, match_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    alu_cmd_t             cmd;
    logic [31:0]          alu_res;
    logic [15:0]          ks_t;
    logic                 req_take;
    logic                 rsp_free;
    logic                 cfg_wr;

    zipc_alu u_alu (
        .cmd (cmd),
        .res (alu_res)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // keystream operand: low 16 bits of key_c with bit 1 forced
    assign ks_t = key_c_reg[15:0] | 16'h0002;

    // operand steering for the shared unit
    always_comb
    begin
        cmd = '{sel: ALU_MUL, opa: {16'd0, ks_t}, opb: {16'd0, ks_t ^ 16'h0001}};
        unique case (state_reg)
            S_KA:    cmd = '{sel: ALU_CRC, opa: key_a_reg, opb: {24'd0, byte_reg}};
            S_KB:    cmd = '{sel: ALU_MUL, opa: key_b_reg + {24'd0, key_a_reg[7:0]},
                             opb: LCG_MUL};
            S_KC:    cmd = '{sel: ALU_CRC, opa: key_c_reg, opb: {24'd0, key_b_reg[31:24]}};
            default: ;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        key_a_next     = key_a_reg;
        key_b_next     = key_b_reg;
        key_c_next     = key_c_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        op_next        = op_reg;
        byte_next      = byte_reg;
        done_next      = done_reg;
        match_next     = match_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    op_next    = req.operation;
                    byte_next  = req.data_byte;
                    done_next  = 1'b0;
                    match_next = 1'b0;
                    case (req.operation)
                        OP_RESTART:
                        begin
                            key_a_next   = KEY_A_INIT;
                            key_b_next   = KEY_B_INIT;
                            key_c_next   = KEY_C_INIT;
                            hdr_cnt_next = '0;
                            state_next   = S_OUT;
                        end
                        OP_ABSORB:  state_next = S_KA;
                        OP_DECRYPT: state_next = S_KS;
                        default:    state_next = S_OUT;
                    endcase
                end
            end
            S_KS:
            begin
                byte_next  = byte_reg ^ alu_res[15:8];
                state_next = S_KA;
            end
            S_KA:
            begin
                key_a_next = alu_res;
                state_next = S_KB;
            end
            S_KB:
            begin
                key_b_next = alu_res + 32'd1;
                state_next = S_KC;
            end
            S_KC:
            begin
                key_c_next = alu_res;
                if (op_reg == OP_DECRYPT && hdr_cnt_reg < HDR_LAST)
                begin
                    hdr_cnt_next = hdr_cnt_reg + HDR_ONE;
                    if (hdr_cnt_reg + HDR_ONE == HDR_LAST)
                    begin
                        done_next  = 1'b1;
                        match_next = (byte_reg == check_reg);
                    end
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.plain_byte    = (op_reg == OP_DECRYPT) ? byte_reg : 8'd0;
                    rsp_next.header_done   = done_reg;
                    rsp_next.header_match  = match_reg;
                    state_next             = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_a_reg     <= KEY_A_INIT;
            key_b_reg     <= KEY_B_INIT;
            key_c_reg     <= KEY_C_INIT;
            hdr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            match_reg     <= 1'b0;
            op_reg        <= OP_RESTART;
        end
        else
        begin
            state_reg     <= state_next;
            key_a_reg     <= key_a_next;
            key_b_reg     <= key_b_next;
            key_c_reg     <= key_c_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            done_reg      <= done_next;
            match_reg     <= match_next;
            op_reg        <= op_next;
        end
    end

    // payload only
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        rsp_reg  <= rsp_next;
    end

    // APB register port: header check value at address 0, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_reg <= 8'd0;
        end
        else if (cfg_wr)
        begin
            check_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {24'd0, check_reg} : 32'd0;

endmodule

/* hdl/zipc_checker.sv */
// Port-level checks for zip_traditional_stream_decrypt, bound to the top level.
// Depends on zipc_pkg for the payload structs.
module zipc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input zipc_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input zipc_pkg::rsp_t rsp
);
    import zipc_pkg::*;

    // stalled request is held by the sender
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("request changed while stalled");

    // held response stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // one request at a time: core busy straight after taking one
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while core not busy afterwards");

    // a fresh response only comes out of a busy core
    a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response without request in work");

    a_match_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!rsp.header_match || rsp.header_done))
        else $error("header match without header done");

endmodule

bind zip_traditional_stream_decrypt zipc_checker u_zipc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

/* sim/tb_zip_traditional_stream_decrypt.sv */
// Self-checking bench for zip_traditional_stream_decrypt: traditional ZIP key mixing,
// header check and APB header check register, against an in-bench cipher mirror.
// Depends on zipc_pkg and the RTL of zip_traditional_stream_decrypt.
`timescale 1ns / 1ps

module tb_zip_traditional_stream_decrypt;

    import zipc_pkg::*;

    localparam int          HDR_LEN         = 12;      // encryption header length
    localparam logic [1:0]  OP_UNUSED       = 2'd3;    // spare code: must do nothing
    localparam logic [2:0]  CHECK_ADDR      = 3'd0;    // register 0, byte address 0
    localparam int          LONG_HOLD       = 300;     // long response back-pressure
    localparam int          PHASE_ITEMS     = 336;     // random requests per phase
    localparam int          LIMIT_CYCLES    = 400000;
    localparam int          MAX_PRINTS      = 200;

    // Cipher state as the block should hold it: three keys, header count and
    // the check byte currently programmed.
    typedef struct packed {
        logic [31:0] key_a;
        logic [31:0] key_b;
        logic [31:0] key_c;
        logic [3:0]  hdr_cnt;
        logic [7:0]  check;
    } zip_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // mirror tracks accepted requests; planner tracks queued ones so that the
    // generator can aim the last header byte at the check byte.
    zip_state_t  mirror;
    zip_state_t  planner;
    req_t        queued_requests[$];
    rsp_t        due_responses[$];

    int          err_count = 0;
    int          cycles = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          idle_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    int          hold_go = 0;
    int          hold_seen = 0;
    logic        next_stall;
    rsp_t        predicted;
    rsp_t        observed_due;

    zip_traditional_stream_decrypt #(
        .HEADER_BYTES (HDR_LEN)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------------
    // Cipher mirror
    // ---------------------------------------------------------------------

    // Raw reflected CRC-32 byte step, no inversion, bit at a time.
    function automatic logic [31:0] crc_byte_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] v;
        int          i;
        v = {24'd0, crc[7:0] ^ b};
        for (i = 0; i < 8; i++)
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        return (crc >> 8) ^ v;
    endfunction

    // Keystream byte: bits 15..8 of t*(t^1), t = low half of key_c with bit 1 set.
    function automatic logic [7:0] keystream_byte(input logic [31:0] kc);
        logic [15:0] t;
        logic [31:0] p;
        t = kc[15:0] | 16'h0002;
        p = 32'(t) * 32'(t ^ 16'h0001);
        return p[15:8];
    endfunction

    task automatic absorb_byte(inout zip_state_t s, input logic [7:0] b);
        s.key_a = crc_byte_step(s.key_a, b);
        s.key_b = (s.key_b + 32'(s.key_a[7:0])) * LCG_MUL + 32'd1;
        s.key_c = crc_byte_step(s.key_c, s.key_b[31:24]);
    endtask

    // One request through the cipher: updates the state, gives the response.
    task automatic run_cipher_step(inout zip_state_t s, input req_t r, output rsp_t o);
        o = '0;
        case (r.operation)
            OP_RESTART:
            begin
                s.key_a   = KEY_A_INIT;
                s.key_b   = KEY_B_INIT;
                s.key_c   = KEY_C_INIT;
                s.hdr_cnt = '0;
            end
            OP_ABSORB:
                absorb_byte(s, r.data_byte);
            OP_DECRYPT:
            begin
                o.plain_byte = r.data_byte ^ keystream_byte(s.key_c);
                absorb_byte(s, o.plain_byte);
                // count saturates once the header is through
                if (s.hdr_cnt < HDR_LEN)
                begin
                    s.hdr_cnt = s.hdr_cnt + 4'd1;
                    if (s.hdr_cnt == HDR_LEN)
                    begin
                        o.header_done  = 1'b1;
                        o.header_match = (o.plain_byte == s.check);
                    end
                end
            end
            default:
            begin
                // unused code: state untouched, all-zero response
            end
        endcase
    endtask

    task automatic flag_error(input string msg);
        if (err_count < MAX_PRINTS)
            $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // ---------------------------------------------------------------------
    // Request driver: feeds queued requests, holds payload while stalled,
    // idles in random bursts. Predicts at each accepted request.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            idle_left = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                run_cipher_step(mirror, req, predicted);
                due_responses.push_back(predicted);
            end
            // a stalled request stays put, payload and all
            if (!(req_valid && req_stall))
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    req_valid <= 1'b0;
                end
                else if (queued_requests.size() != 0 && idle_pct != 0
                         && $urandom_range(99) < idle_pct)
                begin
                    idle_left = $urandom_range(0, 10);
                    req_valid <= 1'b0;
                end
                else if (queued_requests.size() != 0)
                begin
                    req_valid <= 1'b1;
                    req       <= queued_requests.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Response back-pressure: random bursts, plus one long hold on request
    // from the main sequence so the block backs up into req_stall.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            next_stall = 1'b0;
            if (hold_seen != hold_go)
            begin
                hold_seen = hold_go;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_stall = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                next_stall = 1'b1;
            end
            else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 10);
                next_stall = 1'b1;
            end
            rsp_stall <= next_stall;
        end
    end

    // ---------------------------------------------------------------------
    // Response monitor: field-by-field against the oldest due response.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (due_responses.size() == 0)
                flag_error($sformatf("unexpected response %h", rsp));
            else
            begin
                observed_due = due_responses.pop_front();
                if (rsp.plain_byte !== observed_due.plain_byte)
                    flag_error($sformatf("plain_byte %h, want %h",
                                         rsp.plain_byte, observed_due.plain_byte));
                if (rsp.header_done !== observed_due.header_done)
                    flag_error($sformatf("header_done %b, want %b",
                                         rsp.header_done, observed_due.header_done));
                if (rsp.header_match !== observed_due.header_match)
                    flag_error($sformatf("header_match %b, want %b",
                                         rsp.header_match, observed_due.header_match));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb_zip_traditional_stream_decrypt NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------

    // Queue one request. On the last header byte, half the time pick the
    // cipher byte so that it decrypts to the check byte.
    task automatic queue_request(input logic [1:0] op, input logic [7:0] data);
        req_t r;
        rsp_t scratch;
        r.operation = op;
        r.data_byte = data;
        if (op == OP_DECRYPT && planner.hdr_cnt == HDR_LEN - 1 && $urandom_range(1) == 0)
            r.data_byte = planner.check ^ keystream_byte(planner.key_c);
        run_cipher_step(planner, r, scratch);
        queued_requests.push_back(r);
    endtask

    // Mostly well-formed sessions (restart, password, header, payload) with
    // random content; some broken sessions and some raw noise.
    task automatic queue_traffic(input int n);
        int queued;
        int k;
        int hdr;
        queued = 0;
        while (queued < n)
        begin
            if ($urandom_range(99) < 15)
            begin
                k = $urandom_range(1, 4);
                repeat (k) queue_request(2'($urandom_range(0, 3)), 8'($urandom));
                queued += k;
            end
            else
            begin
                queue_request(OP_RESTART, 8'($urandom));
                k = $urandom_range(0, 8);
                repeat (k) queue_request(OP_ABSORB, 8'($urandom));
                queued += k + 1;
                // a short header now and then, absorbs slipped in now and then
                hdr = ($urandom_range(9) == 0) ? $urandom_range(1, HDR_LEN - 1) : HDR_LEN;
                repeat (hdr)
                begin
                    if ($urandom_range(19) == 0)
                    begin
                        queue_request(OP_ABSORB, 8'($urandom));
                        queued++;
                    end
                    queue_request(OP_DECRYPT, 8'($urandom));
                    queued++;
                end
                k = $urandom_range(0, 6);
                repeat (k) queue_request(OP_DECRYPT, 8'($urandom));
                queued += k;
            end
        end
    endtask

    // Sender pause: everything offered, accepted and answered.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (queued_requests.size() != 0 || req_valid !== 1'b0 || due_responses.size() != 0);
    endtask

    // APB write: setup then access; lands on the edge with pready high.
    task automatic write_check_value(input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CHECK_ADDR;
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mirror.check  = value;
        planner.check = value;
        @(negedge clk);
    endtask

    initial
    begin
        int         ph;
        logic [7:0] check_val;

        mirror.key_a   = KEY_A_INIT;
        mirror.key_b   = KEY_B_INIT;
        mirror.key_c   = KEY_C_INIT;
        mirror.hdr_cnt = '0;
        mirror.check   = 8'd0;
        planner        = mirror;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: spare code, restart with data ignored, password extremes,
        // a full header straight from reset, saturation past the header,
        // and a restart ahead of a fresh decrypt. Check byte at reset value.
        idle_pct  = 10;
        stall_pct = 10;
        queue_request(OP_UNUSED, 8'hFF);
        queue_request(OP_RESTART, 8'hFF);
        queue_request(OP_ABSORB, 8'h00);
        queue_request(OP_ABSORB, 8'hFF);
        queue_request(OP_DECRYPT, 8'h00);
        queue_request(OP_DECRYPT, 8'hFF);
        repeat (HDR_LEN - 2) queue_request(OP_DECRYPT, 8'($urandom));
        queue_request(OP_DECRYPT, 8'h55);
        queue_request(OP_UNUSED, 8'h00);
        queue_request(OP_RESTART, 8'h00);
        queue_request(OP_DECRYPT, 8'hA5);
        wait_drained();

        // Random phases, each with its own check byte and pacing; the last
        // runs flat out on both sides.
        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:       check_val = 8'hFF;
                1:       check_val = 8'h00;
                default: check_val = 8'($urandom);
            endcase
            write_check_value(check_val);
            case (ph)
                0:
                begin
                    idle_pct  = 20;
                    stall_pct = 20;
                    hold_go++;          // long hold while the sender keeps offering
                end
                1:
                begin
                    idle_pct  = 0;
                    stall_pct = 40;
                end
                2:
                begin
                    idle_pct  = 35;
                    stall_pct = 0;
                end
                3:
                begin
                    idle_pct  = 15;
                    stall_pct = 15;
                end
                default:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase
            queue_traffic(PHASE_ITEMS);
            wait_drained();
        end

        // let any stray response show itself
        repeat (20) @(negedge clk);
        if (err_count == 0 && due_responses.size() == 0)
            $display("tb_zip_traditional_stream_decrypt OK");
        else
            $display("tb_zip_traditional_stream_decrypt NOT OK");
        $finish;
    end

endmodule
